[rtl/nmea_sentence_checker_defines.svh]
// Assertion macros shared by the sentence checker RTL.
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NMEA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nmea_sentence_checker: assertion failed");

// Next-cycle implication, disabled during reset.
`define NMEA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nmea_sentence_checker: assertion failed");

`endif

[rtl/nmea_pkg.sv]
// Shared constants, types and decode functions of the sentence checker.
`default_nettype none

package nmea_pkg;

   localparam int MAX_LINE = 128;
   localparam int COUNT_W  = $clog2(MAX_LINE);
   localparam int LEN_W    = 7;
   localparam int ID_BYTES = 5;

   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   typedef enum logic [2:0] {
      ST_VALID    = 3'd0,
      ST_NO_STAR  = 3'd1,
      ST_BAD_HEX  = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_SHORT    = 3'd4
   } status_type;

   localparam logic [2:0] KIND_UNKNOWN = 3'd0;
   localparam logic [2:0] KIND_RMC     = 3'd1;
   localparam logic [2:0] KIND_GGA     = 3'd2;
   localparam logic [2:0] KIND_GSA     = 3'd3;
   localparam logic [2:0] KIND_GSV     = 3'd4;
   localparam logic [2:0] KIND_VTG     = 3'd5;
   localparam logic [2:0] KIND_RME     = 3'd6;

   // Identifiers packed with the first character in the low byte.
   localparam logic [39:0] ID_GPRMC = 40'h43_4D_52_50_47;
   localparam logic [39:0] ID_GPGGA = 40'h41_47_47_50_47;
   localparam logic [39:0] ID_GNGGA = 40'h41_47_47_4E_47;
   localparam logic [39:0] ID_GPGSA = 40'h41_53_47_50_47;
   localparam logic [39:0] ID_GNGSA = 40'h41_53_47_4E_47;
   localparam logic [39:0] ID_GPGSV = 40'h56_53_47_50_47;
   localparam logic [39:0] ID_GNGSV = 40'h56_53_47_4E_47;
   localparam logic [39:0] ID_GPVTG = 40'h47_54_56_50_47;
   localparam logic [39:0] ID_GNVTG = 40'h47_54_56_4E_47;
   localparam logic [39:0] ID_PGRME = 40'h45_4D_52_47_50;

   typedef enum logic [5:0] {
      PH_PAYLOAD = 6'b000001,
      PH_HEX_HI  = 6'b000010,
      PH_HEX_LO  = 6'b000100,
      PH_DONE    = 6'b001000,
      PH_STOP    = 6'b010000,
      PH_BAD_HEX = 6'b100000
   } phase_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  sentence_kind;
      logic [7:0]  computed_sum;
      logic [7:0]  received_sum;
      logic [LEN_W-1:0] line_length;
   } result_type;

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] n;
      n = 5'h10;
      if (b inside {[8'h30:8'h39]}) begin
         n = {1'b0, 4'(b - 8'h30)};
      end else if (b inside {[8'h41:8'h46]}) begin
         n = {1'b0, 4'(b - 8'h37)};
      end else if (b inside {[8'h61:8'h66]}) begin
         n = {1'b0, 4'(b - 8'h57)};
      end
      return n;
   endfunction

   function automatic logic [2:0] kind_of(input logic [39:0] id);
      logic [2:0] k;
      k = KIND_UNKNOWN;
      if (id == ID_GPRMC) begin
         k = KIND_RMC;
      end else if (id == ID_GPGGA || id == ID_GNGGA) begin
         k = KIND_GGA;
      end else if (id == ID_GPGSA || id == ID_GNGSA) begin
         k = KIND_GSA;
      end else if (id == ID_GPGSV || id == ID_GNGSV) begin
         k = KIND_GSV;
      end else if (id == ID_GPVTG || id == ID_GNVTG) begin
         k = KIND_VTG;
      end else if (id == ID_PGRME) begin
         k = KIND_RME;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/nmea_scan.sv]
// Per-line scan state: length, payload XOR, star and hex digit tracking.
`default_nettype none

module nmea_scan
   import nmea_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output logic            emit,
   output result_type      result
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         got_ff, got_in;
   logic [39:0]        id_ff, id_in;
   logic               short_ff, short_in;
   logic               dollar_ff, dollar_in;

   logic               is_nl;
   logic               full;
   logic [4:0]         nib;

   assign is_nl = (rx_byte == CHAR_NL);
   assign full  = (count_ff == COUNT_W'(MAX_LINE - 1));
   assign nib   = hex_nibble(rx_byte);
   assign emit  = step && is_nl && (count_ff > COUNT_W'(6)) && dollar_ff;

   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      phase_in  = phase_ff;
      got_in    = got_ff;
      id_in     = id_ff;
      short_in  = short_ff;
      dollar_in = dollar_ff;
      if (step) begin
         if (is_nl || full) begin
            // line ends or overflows: restart empty
            count_in  = '0;
            sum_in    = '0;
            phase_in  = PH_PAYLOAD;
            got_in    = '0;
            id_in     = '0;
            short_in  = 1'b0;
            dollar_in = 1'b0;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == '0) begin
               dollar_in = (rx_byte == CHAR_DOLLAR);
            end else begin
               for (int k = 0; k < ID_BYTES; k++) begin
                  if (count_ff == COUNT_W'(k + 1)) begin
                     id_in[8*k +: 8] = rx_byte;
                  end
               end
               case (phase_ff)
                  PH_PAYLOAD: begin
                     if (rx_byte == CHAR_STAR) begin
                        phase_in = PH_HEX_HI;
                        short_in = (count_ff < COUNT_W'(3));
                     end else if (rx_byte == CHAR_NUL || rx_byte == CHAR_CR) begin
                        phase_in = PH_STOP;
                     end else begin
                        sum_in = sum_ff ^ rx_byte;
                     end
                  end
                  PH_HEX_HI: begin
                     if (!nib[4]) begin
                        got_in   = {nib[3:0], 4'h0};
                        phase_in = PH_HEX_LO;
                     end else begin
                        phase_in = PH_BAD_HEX;
                     end
                  end
                  PH_HEX_LO: begin
                     if (!nib[4]) begin
                        got_in   = {got_ff[7:4], nib[3:0]};
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_BAD_HEX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   // Result as seen when the current line ends now.
   always_comb begin
      result.status        = ST_BAD_HEX;
      result.sentence_kind = KIND_UNKNOWN;
      result.computed_sum  = sum_ff;
      result.received_sum  = '0;
      result.line_length   = LEN_W'(count_ff);
      case (phase_ff)
         PH_PAYLOAD, PH_STOP: begin
            result.status = ST_NO_STAR;
         end
         PH_DONE: begin
            result.received_sum = got_ff;
            if (got_ff != sum_ff) begin
               result.status = ST_MISMATCH;
            end else if (short_ff) begin
               result.status = ST_SHORT;
            end else begin
               result.status        = ST_VALID;
               result.sentence_kind = kind_of(id_ff);
            end
         end
         default: begin
            result.status = ST_BAD_HEX;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         phase_ff  <= PH_PAYLOAD;
         got_ff    <= '0;
         id_ff     <= '0;
         short_ff  <= 1'b0;
         dollar_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         phase_ff  <= phase_in;
         got_ff    <= got_in;
         id_ff     <= id_in;
         short_ff  <= short_in;
         dollar_ff <= dollar_in;
      end
   end

endmodule

`default_nettype wire

[rtl/nmea_sentence_checker.sv]
// Top level of the NMEA sentence checker: input register, scan, result register.
// Takes one received character per request and reports one result per
// newline-terminated line of more than six characters that starts with '$':
// status, sentence kind, computed and received checksums, and line length.
// Requests can follow back to back. A request goes through an input register,
// the line scan logic and a result register. The input side stalls only when
// a newline waits in the input register while the result register holds a
// result that the receiver is stalling.
`default_nettype none

module nmea_sentence_checker
   import nmea_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [2:0]            rsp_sentence_kind,
   output logic [7:0]            rsp_computed_sum,
   output logic [7:0]            rsp_received_sum,
   output logic [LEN_W-1:0]      rsp_line_length
);

`include "nmea_sentence_checker_defines.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       out_free;
   logic       advance;
   logic       emit;
   result_type scan_result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   // non-newline bytes never wait for the result side
   assign advance   = in_valid_ff && (out_free || (in_byte_ff != CHAR_NL));
   assign req_stall = in_valid_ff && !advance;

   nmea_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (scan_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = scan_result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_sentence_kind = out_ff.sentence_kind;
   assign rsp_computed_sum  = out_ff.computed_sum;
   assign rsp_received_sum  = out_ff.received_sum;
   assign rsp_line_length   = out_ff.line_length;

   `NMEA_ASSERT_IMPLIES(a_kind_only_valid, clock, reset,
      rsp_valid && (rsp_status != ST_VALID), rsp_sentence_kind == KIND_UNKNOWN)
   `NMEA_ASSERT_IMPLIES(a_no_star_no_sum, clock, reset,
      rsp_valid && (rsp_status == ST_NO_STAR || rsp_status == ST_BAD_HEX),
      rsp_received_sum == 8'h00)
   `NMEA_ASSERT_IMPLIES(a_stall_only_newline, clock, reset,
      req_stall, in_valid_ff && (in_byte_ff == CHAR_NL) && out_valid_ff && rsp_stall)
   `NMEA_ASSERT_NEXT(a_emit_shows, clock, reset,
      emit, rsp_valid)

endmodule

`default_nettype wire
